### rtl/edc_pkg.sv
// edc_pkg: shared types, operation codes and helpers for the edit distance engine
// no dependencies; imported by edit_distance_engine
package edc_pkg;

    // request operation codes carried on s_tuser
    typedef enum logic [1:0] {
        FUNC_REF = 2'd0,   // append reference character
        FUNC_QRY = 2'd1,   // process query character
        FUNC_RPT = 2'd2,   // report distance and clear
        FUNC_NOP = 2'd3    // unused, ignored
    } func_t;

    localparam int CHAR_W   = 8;
    localparam int DIST_W   = 7;
    localparam int DIST_SAT = 127;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_REPORT = 3'b100
    } state_t;

    // fold ascii upper case letters to lower case
    function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

### rtl/edc_ram.sv
// edc_ram: generic simple dual port ram, one write and one registered read
// no dependencies; used for the reference store and the dp row
module edc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/edc_cell.sv
// edc_cell: one levenshtein cell update, shared across every column of the row
// no dependencies; instantiated once by edit_distance_engine
module edc_cell #(
    parameter int DW = 7
) (
    input  logic [DW-1:0] above,
    input  logic [DW-1:0] left,
    input  logic [DW-1:0] diag,
    input  logic [7:0]    ref_ch,
    input  logic [7:0]    qry_ch,
    output logic [DW-1:0] cell_out
);

    logic [DW-1:0] min_al;
    logic [DW-1:0] min_all;
    logic [DW:0]   min_inc;

    always_comb
    begin
        min_al   = (above < left) ? above : left;
        min_all  = (min_al < diag) ? min_al : diag;
        min_inc  = {1'b0, min_all} + {{DW{1'b0}}, 1'b1};
        cell_out = (ref_ch == qry_ch) ? diag : min_inc[DW-1:0];
    end

endmodule

### rtl/edit_distance_engine.sv
// edit_distance_engine: case-insensitive levenshtein distance over one stored dp row
// depends on edc_pkg, edc_ram and edc_cell
//
// channel | dir | tvalid/tready   | payload
// --------+-----+-----------------+--------------------------------------------
// s       | in  | s_tvalid/tready | s_tuser[1:0] func, s_tdata[7:0] ch
// m       | out | m_tvalid/tready | m_tdata[6:0] distance, m_tdata[7] overflow
//
// an append request is done in idle; a query request with a non-empty reference
// then scans the row, one row cell per cycle through the shared cell unit and
// the dp ram read port; a report request waits in ST_REPORT for the output slot
// rst_n clears all control state; ram contents stay undefined and are
// always written before they are read
// the single output register lets the engine take new requests while a
// result waits; a further report waits until that slot drains
module edit_distance_engine #(
    parameter int MAX_LEN = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic [1:0] s_tuser,   // [1:0] func
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [6:0] distance, [7] overflow
);

    import edc_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;  // ram address width
    localparam int CW = $clog2(MAX_LEN + 1);                  // counts up to MAX_LEN
    localparam int DW = CW;                                   // dp cell values

    state_t          state_reg, state_next;
    logic [CW-1:0]   ref_len_reg, ref_len_next;
    logic [CW-1:0]   qcnt_reg, qcnt_next;
    logic            ovf_reg, ovf_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [DW-1:0]   diag_reg, diag_next;
    logic [DW-1:0]   left_reg, left_next;
    logic [7:0]      qch_reg, qch_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_data_reg, out_data_next;

    logic            accept;
    func_t           func_in;
    logic [7:0]      ch_folded;
    logic [CW-1:0]   ref_len_inc;
    logic [CW-1:0]   qcnt_inc;
    logic [AW-1:0]   last_addr;
    logic            scan_last;

    // ram ports
    logic            ch_we;
    logic            dp_we;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr;
    logic [DW-1:0]   dp_wdata;
    logic [7:0]      ch_rdata;
    logic [DW-1:0]   dp_rdata;
    logic [DW-1:0]   cell_out;

    // report value and saturation
    logic [DW-1:0]   dist_val;
    logic [31:0]     dist_ext;
    logic [DIST_W-1:0] dist_sat;
    logic            slot_free;

    assign accept      = s_tvalid && s_tready;
    assign func_in     = func_t'(s_tuser);
    assign ch_folded   = fold_lower(s_tdata);
    assign ref_len_inc = ref_len_reg + {{(CW-1){1'b0}}, 1'b1};
    assign qcnt_inc    = qcnt_reg + {{(CW-1){1'b0}}, 1'b1};
    // address of the last stored cell, dp row entry ref_length
    assign last_addr   = (ref_len_reg == '0) ? '0 : AW'(ref_len_reg - {{(CW-1){1'b0}}, 1'b1});
    assign scan_last   = (idx_reg == last_addr);
    assign slot_free   = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // reference characters, one folded char per position
    edc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LEN)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ch_we),
        .waddr (waddr),
        .wdata (ch_folded),
        .raddr (raddr),
        .rdata (ch_rdata)
    );

    // dp row entries 1..MAX_LEN at address j-1; entry 0 equals the query count
    edc_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_LEN)
    ) u_dp_ram (
        .clk   (clk),
        .we    (dp_we),
        .waddr (waddr),
        .wdata (dp_wdata),
        .raddr (raddr),
        .rdata (dp_rdata)
    );

    edc_cell #(
        .DW (DW)
    ) u_cell (
        .above    (dp_rdata),
        .left     (left_reg),
        .diag     (diag_reg),
        .ref_ch   (ch_rdata),
        .qry_ch   (qch_reg),
        .cell_out (cell_out)
    );

    // distance: entry 0 when the reference is empty, else the last stored cell
    always_comb
    begin
        dist_val = (ref_len_reg == '0) ? qcnt_reg : dp_rdata;
        dist_ext = {{(32-DW){1'b0}}, dist_val};
        dist_sat = (dist_ext > 32'(DIST_SAT)) ? DIST_W'(DIST_SAT) : dist_ext[DIST_W-1:0];
    end

    // read address runs one cell ahead of the write during a scan
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                raddr = (func_in == FUNC_RPT) ? last_addr : '0;
            end
            ST_SCAN:
            begin
                raddr = scan_last ? idx_reg : idx_reg + {{(AW-1){1'b0}}, 1'b1};
            end
            ST_REPORT:
            begin
                raddr = last_addr;
            end
            default:
            begin
                raddr = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ref_len_next   = ref_len_reg;
        qcnt_next      = qcnt_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        diag_next      = diag_reg;
        left_next      = left_reg;
        qch_next       = qch_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ch_we          = 1'b0;
        dp_we          = 1'b0;
        waddr          = idx_reg;
        dp_wdata       = cell_out;

        // output slot drains on its own handshake
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func_in)
                        FUNC_REF:
                        begin
                            // appends after a query char are dropped silently
                            if (qcnt_reg == '0)
                            begin
                                if (ref_len_reg == CW'(MAX_LEN))
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    ch_we        = 1'b1;
                                    dp_we        = 1'b1;
                                    waddr        = AW'(ref_len_reg);
                                    dp_wdata     = DW'(ref_len_inc);
                                    ref_len_next = ref_len_inc;
                                end
                            end
                        end
                        FUNC_QRY:
                        begin
                            if (qcnt_reg == CW'(MAX_LEN))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                qcnt_next = qcnt_inc;
                                diag_next = DW'(qcnt_reg);
                                left_next = DW'(qcnt_inc);
                                qch_next  = ch_folded;
                                idx_next  = '0;
                                if (ref_len_reg != '0)
                                begin
                                    state_next = ST_SCAN;
                                end
                            end
                        end
                        FUNC_RPT:
                        begin
                            state_next = ST_REPORT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // one row cell per cycle
                dp_we     = 1'b1;
                waddr     = idx_reg;
                dp_wdata  = cell_out;
                left_next = cell_out;
                diag_next = dp_rdata;
                if (scan_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + {{(AW-1){1'b0}}, 1'b1};
                end
            end
            ST_REPORT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {ovf_reg, dist_sat};
                    ref_len_next   = '0;
                    qcnt_next      = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ref_len_reg   <= '0;
            qcnt_reg      <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ref_len_reg   <= ref_len_next;
            qcnt_reg      <= qcnt_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        diag_reg     <= diag_next;
        left_reg     <= left_next;
        qch_reg      <= qch_next;
        out_data_reg <= out_data_next;
    end

endmodule
